// File: sv/whtlp_pkg.sv
// Package: shared types, constants and codes for the word hash table.
`timescale 1ns / 1ps
package whtlp_pkg;
    localparam int SLOTS_DEF = 1024;
    localparam int MAX_WORD_LEN_DEF = 29;
    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1024;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_COLLECT,
        S_MOD,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_WRITE,
        S_RESULT
    } state_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;
endpackage

// File: sv/whtlp_if.sv
// Interfaces: valid/ready channels for input bytes and word results.
`timescale 1ns / 1ps
interface whtlp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_code;
    logic       last_char;
    modport source (output valid, op, char_code, last_char, input ready);
    modport sink (input valid, op, char_code, last_char, output ready);
endinterface

interface whtlp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [9:0]  home_slot;
    logic [10:0] probe_count;
    logic [10:0] entries_stored;
    modport source (output valid, status, slot, home_slot, probe_count, entries_stored,
                    input ready);
    modport sink (input valid, status, slot, home_slot, probe_count, entries_stored,
                  output ready);
endinterface

// File: sv/whtlp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module whtlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/whtlp_mod.sv
// Restoring bit-serial modulo of a 64-bit hash by the table size.
`timescale 1ns / 1ps
module whtlp_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [10:0] divisor,
    output logic        done,
    output logic [10:0] remainder
);
    logic [63:0] quot_reg, quot_next;
    logic [10:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [11:0] shifted;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[63]};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[62:0], 1'b0};
            rem_next  = (shifted >= {1'b0, divisor}) ? 11'(shifted - {1'b0, divisor})
                                                     : shifted[10:0];
            cnt_next  = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done      = busy_reg && (cnt_reg == 7'd1);
    assign remainder = rem_next;
endmodule

// File: sv/word_hash_table_linear_probe_top.sv
// Word hash table with linear probing: top level, controller and table memories.
//
// Usage: bytes of a word arrive on the in channel, one beat per byte; the beat
// with last_char set closes the word and its op picks insert or search.
// Each closing beat yields one beat on the out channel with status, slot,
// home slot, probe count and the number of stored words. Other beats yield none.
// After a closing byte the hash modulo runs, one remainder bit per cycle, and
// its remainder is loaded as the home slot. Each probed slot then passes
// S_PROBE_RD and S_PROBE_CHK for the slot state read, and each byte compared
// passes S_CMP_RD and S_CMP_CHK, since every character lives in one memory
// with one read port. A new insert then writes its bytes in S_WRITE (no byte
// for an empty word). One word is processed at a time; the next byte is
// accepted once the result has been loaded into the output register.
// After reset the valid marks of all slots are cleared by a pass over all
// SLOTS slots during which no byte is accepted; table_size resets to 1024.
// The result is held in an output register until taken; while the receiver
// stalls the next word is still collected and processed, and its result waits
// until the held one is taken.
// table_size may be written via cfg_we/cfg_data when no word is in flight.
`timescale 1ns / 1ps
module word_hash_table_linear_probe_top #(
    parameter int SLOTS        = whtlp_pkg::SLOTS_DEF,
    parameter int MAX_WORD_LEN = whtlp_pkg::MAX_WORD_LEN_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [whtlp_pkg::CFG_W-1:0] cfg_data,
    whtlp_in_if.sink                 in_ch,
    whtlp_out_if.source              out_ch
);
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int LW  = $clog2(MAX_WORD_LEN + 1);
    localparam int BW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int CHD = SLOTS * MAX_WORD_LEN;
    localparam int AW  = (CHD > 1) ? $clog2(CHD) : 1;

    whtlp_pkg::state_t state_reg, state_next;

    logic [whtlp_pkg::CFG_W-1:0] tsize_reg;
    logic [CW-1:0]   size_eff;
    logic [63:0]     hash_reg, hash_next;
    logic [LW-1:0]   wlen_reg, wlen_next;
    logic            closed_reg, closed_next;
    logic            op_reg, op_next;
    logic [7:0]      wbuf_reg [MAX_WORD_LEN];
    logic [CW-1:0]   count_reg, count_next;
    logic            clr_reg, clr_next;
    logic [SW-1:0]   clr_idx_reg, clr_idx_next;
    logic [SW-1:0]   home_reg, home_next;
    logic [SW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   probes_reg, probes_next;
    logic [LW-1:0]   bi_reg, bi_next;
    logic [2:0]      status_reg, status_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [CW-1:0]   pcnt_reg, pcnt_next;
    logic            ovalid_reg, ovalid_next;
    logic [2:0]      ostatus_reg, ostatus_next;
    logic [SW-1:0]   oslot_reg, oslot_next;
    logic [SW-1:0]   ohome_reg, ohome_next;
    logic [CW-1:0]   opcnt_reg, opcnt_next;
    logic [CW-1:0]   ocount_reg, ocount_next;

    // slot state memory: valid mark and word length
    logic            st_we;
    logic [SW-1:0]   st_waddr, st_raddr;
    logic [LW:0]     st_wdata, st_rdata;
    logic            ch_we;
    logic [AW-1:0]   ch_waddr, ch_raddr;
    logic [7:0]      ch_wdata, ch_rdata;

    logic            mod_start, mod_done;
    logic [10:0]     mod_rem;
    logic            in_fire, out_fire;
    logic [BW-1:0]   wl_idx, bi_idx;
    logic [SW-1:0]   pos_inc;
    logic [AW-1:0]   ch_base;

    whtlp_ram #(.WIDTH(LW + 1), .DEPTH(SLOTS)) u_state_ram (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    whtlp_ram #(.WIDTH(8), .DEPTH(CHD)) u_char_ram (
        .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr), .rdata(ch_rdata)
    );

    // the closing byte's hash update lands in the same cycle as the start
    whtlp_mod u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(hash_next),
        .divisor(11'(size_eff)), .done(mod_done), .remainder(mod_rem)
    );

    always_comb
    begin
        if (tsize_reg == '0)
        begin
            size_eff = CW'(1);
        end
        else if ({21'd0, tsize_reg} > 32'(SLOTS))
        begin
            size_eff = CW'(SLOTS);
        end
        else
        begin
            size_eff = CW'(tsize_reg);
        end
    end

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == whtlp_pkg::S_COLLECT) && !clr_reg;
    assign wl_idx   = BW'(wlen_reg);
    assign bi_idx   = BW'(bi_reg);
    assign pos_inc  = ({{(32-SW){1'b0}}, pos_reg} + 32'd1 >= 32'(size_eff)) ? '0 : pos_reg + SW'(1);
    assign ch_base  = AW'(pos_reg) * AW'(MAX_WORD_LEN);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            whtlp_pkg::S_COLLECT:
            begin
                if (in_fire && in_ch.last_char)
                begin
                    state_next = whtlp_pkg::S_MOD;
                end
            end
            whtlp_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    if (op_reg == whtlp_pkg::OP_INSERT && count_reg >= size_eff)
                    begin
                        state_next = whtlp_pkg::S_RESULT;
                    end
                    else
                    begin
                        state_next = whtlp_pkg::S_PROBE_RD;
                    end
                end
            end
            whtlp_pkg::S_PROBE_RD:  state_next = whtlp_pkg::S_PROBE_CHK;
            whtlp_pkg::S_PROBE_CHK:
            begin
                if (!st_rdata[LW])
                begin
                    state_next = (op_reg == whtlp_pkg::OP_INSERT) ? whtlp_pkg::S_WRITE
                                                                 : whtlp_pkg::S_RESULT;
                end
                else if (st_rdata[LW-1:0] != wlen_reg)
                begin
                    state_next = (probes_reg + CW'(1) >= size_eff) ? whtlp_pkg::S_RESULT
                                                                  : whtlp_pkg::S_PROBE_RD;
                end
                else if (wlen_reg == '0)
                begin
                    state_next = whtlp_pkg::S_RESULT;
                end
                else
                begin
                    state_next = whtlp_pkg::S_CMP_RD;
                end
            end
            whtlp_pkg::S_CMP_RD:    state_next = whtlp_pkg::S_CMP_CHK;
            whtlp_pkg::S_CMP_CHK:
            begin
                if (ch_rdata != wbuf_reg[bi_idx])
                begin
                    state_next = (probes_reg + CW'(1) >= size_eff) ? whtlp_pkg::S_RESULT
                                                                  : whtlp_pkg::S_PROBE_RD;
                end
                else if (bi_reg + LW'(1) == wlen_reg)
                begin
                    state_next = whtlp_pkg::S_RESULT;
                end
                else
                begin
                    state_next = whtlp_pkg::S_CMP_RD;
                end
            end
            whtlp_pkg::S_WRITE:
            begin
                if (bi_reg + LW'(1) >= wlen_reg)
                begin
                    state_next = whtlp_pkg::S_RESULT;
                end
            end
            whtlp_pkg::S_RESULT:
            begin
                // hold until the output register is free
                if (!ovalid_reg || out_fire)
                begin
                    state_next = whtlp_pkg::S_COLLECT;
                end
            end
            default:                state_next = whtlp_pkg::S_COLLECT;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        hash_next   = hash_reg;
        wlen_next   = wlen_reg;
        closed_next = closed_reg;
        op_next     = op_reg;
        count_next  = count_reg;
        clr_next    = clr_reg;
        clr_idx_next = clr_idx_reg;
        home_next   = home_reg;
        pos_next    = pos_reg;
        probes_next = probes_reg;
        bi_next     = bi_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        pcnt_next   = pcnt_reg;
        ovalid_next = ovalid_reg;
        ostatus_next = ostatus_reg;
        oslot_next  = oslot_reg;
        ohome_next  = ohome_reg;
        opcnt_next  = opcnt_reg;
        ocount_next = ocount_reg;
        mod_start   = 1'b0;
        st_we       = 1'b0;
        st_waddr    = pos_reg;
        st_wdata    = {1'b1, wlen_reg};
        st_raddr    = pos_reg;
        ch_we       = 1'b0;
        ch_waddr    = ch_base + AW'(bi_reg);
        ch_wdata    = wbuf_reg[bi_idx];
        ch_raddr    = ch_base + AW'(bi_reg);

        if (out_fire)
        begin
            ovalid_next = 1'b0;
        end
        if (clr_reg)
        begin
            st_we    = 1'b1;
            st_waddr = clr_idx_reg;
            st_wdata = '0;
            clr_idx_next = clr_idx_reg + SW'(1);
            if ({{(32-SW){1'b0}}, clr_idx_reg} == 32'(SLOTS - 1))
            begin
                clr_next = 1'b0;
            end
        end

        unique case (state_reg)
            whtlp_pkg::S_COLLECT:
            begin
                if (in_fire)
                begin
                    if (!closed_reg)
                    begin
                        if (in_ch.char_code == 8'd0)
                        begin
                            closed_next = 1'b1;
                        end
                        else if ({{(32-LW){1'b0}}, wlen_reg} < 32'(MAX_WORD_LEN))
                        begin
                            hash_next = hash_reg * 64'd3 * 64'(wlen_reg)
                                        + 64'(in_ch.char_code);
                            wlen_next = wlen_reg + LW'(1);
                        end
                    end
                    if (in_ch.last_char)
                    begin
                        op_next   = in_ch.op;
                        mod_start = 1'b1;
                    end
                end
            end
            whtlp_pkg::S_MOD:
            begin
                probes_next = '0;
                bi_next     = '0;
                slot_next   = '0;
                pcnt_next   = '0;
                status_next = (op_reg == whtlp_pkg::OP_INSERT) ? 3'(whtlp_pkg::ST_FULL)
                                                              : 3'(whtlp_pkg::ST_NOT_FOUND);
                if (mod_done)
                begin
                    home_next = SW'(mod_rem);
                    pos_next  = SW'(mod_rem);
                end
            end
            whtlp_pkg::S_PROBE_RD:
            begin
                bi_next = '0;
            end
            whtlp_pkg::S_PROBE_CHK:
            begin
                if (!st_rdata[LW])
                begin
                    if (op_reg == whtlp_pkg::OP_INSERT)
                    begin
                        st_we       = 1'b1;
                        count_next  = count_reg + CW'(1);
                        status_next = 3'(whtlp_pkg::ST_INSERTED);
                        slot_next   = pos_reg;
                    end
                end
                else if (st_rdata[LW-1:0] != wlen_reg)
                begin
                    probes_next = probes_reg + CW'(1);
                    pos_next    = pos_inc;
                end
                else if (wlen_reg == '0)
                begin
                    status_next = (op_reg == whtlp_pkg::OP_INSERT) ? 3'(whtlp_pkg::ST_PRESENT)
                                                                  : 3'(whtlp_pkg::ST_FOUND);
                    slot_next   = pos_reg;
                    if (op_reg == whtlp_pkg::OP_SEARCH)
                    begin
                        pcnt_next = probes_reg + CW'(1);
                    end
                end
            end
            whtlp_pkg::S_CMP_RD:
            begin
            end
            whtlp_pkg::S_CMP_CHK:
            begin
                if (ch_rdata != wbuf_reg[bi_idx])
                begin
                    probes_next = probes_reg + CW'(1);
                    pos_next    = pos_inc;
                end
                else if (bi_reg + LW'(1) == wlen_reg)
                begin
                    status_next = (op_reg == whtlp_pkg::OP_INSERT) ? 3'(whtlp_pkg::ST_PRESENT)
                                                                  : 3'(whtlp_pkg::ST_FOUND);
                    slot_next   = pos_reg;
                    if (op_reg == whtlp_pkg::OP_SEARCH)
                    begin
                        pcnt_next = probes_reg + CW'(1);
                    end
                end
                else
                begin
                    bi_next = bi_reg + LW'(1);
                end
            end
            whtlp_pkg::S_WRITE:
            begin
                if (wlen_reg != '0)
                begin
                    ch_we = 1'b1;
                end
                bi_next = bi_reg + LW'(1);
            end
            whtlp_pkg::S_RESULT:
            begin
                if (!ovalid_reg || out_fire)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = status_reg;
                    oslot_next   = slot_reg;
                    ohome_next   = home_reg;
                    opcnt_next   = pcnt_reg;
                    ocount_next  = count_reg;
                    hash_next    = 64'd1;
                    wlen_next    = '0;
                    closed_next  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= whtlp_pkg::S_COLLECT;
            tsize_reg   <= whtlp_pkg::TABLE_SIZE_RESET;
            hash_reg    <= 64'd1;
            wlen_reg    <= '0;
            closed_reg  <= 1'b0;
            count_reg   <= '0;
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_we)
            begin
                tsize_reg <= cfg_data;
            end
            hash_reg    <= hash_next;
            wlen_reg    <= wlen_next;
            closed_reg  <= closed_next;
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        home_reg    <= home_next;
        pos_reg     <= pos_next;
        probes_reg  <= probes_next;
        bi_reg      <= bi_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        pcnt_reg    <= pcnt_next;
        ostatus_reg <= ostatus_next;
        oslot_reg   <= oslot_next;
        ohome_reg   <= ohome_next;
        opcnt_reg   <= opcnt_next;
        ocount_reg  <= ocount_next;
        // capture the byte into the word buffer
        if (state_reg == whtlp_pkg::S_COLLECT && in_fire && !closed_reg
            && in_ch.char_code != 8'd0
            && {{(32-LW){1'b0}}, wlen_reg} < 32'(MAX_WORD_LEN))
        begin
            wbuf_reg[wl_idx] <= in_ch.char_code;
        end
    end

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.status         = ostatus_reg;
    assign out_ch.slot           = 10'(oslot_reg);
    assign out_ch.home_slot      = 10'(ohome_reg);
    assign out_ch.probe_count    = 11'(opcnt_reg);
    assign out_ch.entries_stored = 11'(ocount_reg);

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != whtlp_pkg::S_COLLECT) |-> !in_ch.ready)
        else $error("byte accepted while a word is in work");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("entry count above slot count");
    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == whtlp_pkg::S_RESULT) |=> out_ch.valid)
        else $error("result not presented");
    a_no_clear_work: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> (state_reg == whtlp_pkg::S_COLLECT))
        else $error("probe during clearing pass");
endmodule

// File: sim/tb.sv
// Testbench for the word hash table: random words, table sizes and stalls, scoreboard check.
`timescale 1ns / 1ps
module tb;
    localparam int NSLOT = whtlp_pkg::SLOTS_DEF;
    localparam int MAXLEN = whtlp_pkg::MAX_WORD_LEN_DEF;
    localparam int RAND_WORDS = 282;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    typedef struct packed {
        whtlp_pkg::status_t status;
        logic [9:0]  slot;
        logic [9:0]  home_slot;
        logic [10:0] probe_count;
        logic [10:0] entries_stored;
    } word_result_t;

    class hash_table_scoreboard;
        logic [10:0]  table_size;
        logic [7:0]   cur_word [MAXLEN];
        int           cur_len;
        logic [63:0]  cur_hash;
        bit           closed;
        bit           used [NSLOT];
        logic [7:0]   keys [NSLOT][MAXLEN];
        int           key_len [NSLOT];
        int           stored;
        word_result_t pending [$];
        int           errors;

        function new();
            table_size = whtlp_pkg::TABLE_SIZE_RESET;
            cur_len = 0;
            cur_hash = 64'd1;
            closed = 0;
            stored = 0;
            errors = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        function bit key_equal(int s);
            if (key_len[s] != cur_len) return 0;
            for (int k = 0; k < cur_len; k++)
                if (keys[s][k] != cur_word[k]) return 0;
            return 1;
        endfunction

        function void note_beat(logic op, logic [7:0] ch, logic last);
            int size;
            int home;
            int pos;
            word_result_t r;
            if (!closed) begin
                if (ch == 8'd0)
                    closed = 1;
                else if (cur_len < MAXLEN) begin
                    cur_hash = cur_hash * 64'd3 * 64'(cur_len) + 64'(ch);
                    cur_word[cur_len] = ch;
                    cur_len++;
                end
            end
            if (!last) return;
            size = (table_size == 0) ? 1 : (table_size > NSLOT) ? NSLOT : table_size;
            home = int'(cur_hash % 64'(size));
            r = '0;
            r.home_slot = 10'(home);
            if (op == whtlp_pkg::OP_INSERT) begin
                r.status = whtlp_pkg::ST_FULL;
                if (stored < size) begin
                    for (int i = 0; i < size; i++) begin
                        pos = (home + i) % size;
                        if (!used[pos]) begin
                            used[pos] = 1;
                            for (int k = 0; k < cur_len; k++) keys[pos][k] = cur_word[k];
                            key_len[pos] = cur_len;
                            stored++;
                            r.status = whtlp_pkg::ST_INSERTED;
                            r.slot = 10'(pos);
                            break;
                        end
                        if (key_equal(pos)) begin
                            r.status = whtlp_pkg::ST_PRESENT;
                            r.slot = 10'(pos);
                            break;
                        end
                    end
                end
            end
            else begin
                r.status = whtlp_pkg::ST_NOT_FOUND;
                for (int i = 0; i < size; i++) begin
                    pos = (home + i) % size;
                    if (!used[pos]) break;
                    if (key_equal(pos)) begin
                        r.status = whtlp_pkg::ST_FOUND;
                        r.slot = 10'(pos);
                        r.probe_count = 11'(i + 1);
                        break;
                    end
                end
            end
            r.entries_stored = 11'(stored);
            pending.push_back(r);
            cur_len = 0;
            cur_hash = 64'd1;
            closed = 0;
        endfunction

        function void check_result(word_result_t got);
            word_result_t exp;
            if (pending.size() == 0) begin
                $error("result with nothing pending: status %0d", got.status);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status != exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.slot != exp.slot) begin
                $error("slot: expected %0d, got %0d", exp.slot, got.slot);
                errors++;
            end
            if (got.home_slot != exp.home_slot) begin
                $error("home_slot: expected %0d, got %0d", exp.home_slot, got.home_slot);
                errors++;
            end
            if (got.probe_count != exp.probe_count) begin
                $error("probe_count: expected %0d, got %0d",
                       exp.probe_count, got.probe_count);
                errors++;
            end
            if (got.entries_stored != exp.entries_stored) begin
                $error("entries_stored: expected %0d, got %0d",
                       exp.entries_stored, got.entries_stored);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_data;
    longint      cycles;
    hash_table_scoreboard sb;

    whtlp_in_if  in_ch ();
    whtlp_out_if out_ch ();

    word_hash_table_linear_probe_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_we (cfg_we),
        .cfg_data(cfg_data),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one beat; hold valid until accepted, drop it only for a gap.
    task automatic send_beat(logic op, logic [7:0] ch, logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.char_code <= ch;
        in_ch.last_char <= last;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_beat(op, ch, last);
    endtask

    task automatic send_word(logic [7:0] w [$], logic op);
        logic junk_op;
        if (w.size() == 0) begin
            send_beat(op, 8'd0, 1'b1);
            return;
        end
        for (int k = 0; k < w.size(); k++) begin
            junk_op = 1'($urandom_range(0, 1));
            send_beat((k == w.size() - 1) ? op : junk_op, w[k], k == w.size() - 1);
        end
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_size(logic [10:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.table_size = v;
    endtask

    function automatic void rand_word(ref logic [7:0] w [$], input int maxlen,
                                      input int alpha);
        int n;
        w.delete();
        n = $urandom_range(1, maxlen);
        for (int k = 0; k < n; k++) w.push_back(8'($urandom_range(1, alpha)));
    endfunction

    // Result side: random stalls, check each beat.
    initial
    begin
        word_result_t got;
        int g;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g > 0) begin
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got.status = whtlp_pkg::status_t'(out_ch.status);
            got.slot = out_ch.slot;
            got.home_slot = out_ch.home_slot;
            got.probe_count = out_ch.probe_count;
            got.entries_stored = out_ch.entries_stored;
            sb.check_result(got);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] w [$];
        logic [7:0] dict [$][$];
        logic [10:0] sizes [6];
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = 1'b0;
        in_ch.char_code = '0;
        in_ch.last_char = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty word, zero byte, long word, extreme bytes, both ops.
        send_word(w, whtlp_pkg::OP_SEARCH);
        send_word(w, whtlp_pkg::OP_INSERT);
        send_word(w, whtlp_pkg::OP_INSERT);
        send_beat(whtlp_pkg::OP_INSERT, 8'hFF, 1'b0);
        send_beat(whtlp_pkg::OP_INSERT, 8'h00, 1'b0);
        send_beat(whtlp_pkg::OP_SEARCH, 8'h55, 1'b1);
        w = {8'hFF};
        send_word(w, whtlp_pkg::OP_SEARCH);
        w.delete();
        for (int k = 0; k < 35; k++) w.push_back(8'($urandom_range(1, 255)));
        send_word(w, whtlp_pkg::OP_INSERT);
        send_word(w, whtlp_pkg::OP_SEARCH);
        w = {8'h01, 8'h80, 8'h7F};
        send_word(w, whtlp_pkg::OP_INSERT);
        send_word(w, whtlp_pkg::OP_SEARCH);
        wait_drain();

        // Sizes zero, one, oversized (2047), three and 1024: full and wraparound cases.
        sizes = '{11'd0, 11'd1, 11'd2047, 11'd3, 11'd1024, 11'd1};
        foreach (sizes[s]) begin
            write_size(sizes[s]);
            repeat (RAND_WORDS / 6) begin
                if (dict.size() > 0 && $urandom_range(0, 1)) begin
                    w = dict[$urandom_range(0, dict.size() - 1)];
                    if ($urandom_range(0, 4) == 0 && w.size() > 0) w[0] = w[0] ^ 8'h01;
                end
                else begin
                    rand_word(w, (s == 2) ? 34 : 6, (s == 3) ? 3 : 255);
                    dict.push_back(w);
                end
                // Occasionally inject a zero byte before the word's last byte.
                if ($urandom_range(0, 15) == 0 && w.size() > 1)
                    w[$urandom_range(0, w.size() - 2)] = 8'h00;
                send_word(w, 1'($urandom_range(0, 1)));
            end
            wait_drain();
            if (s == 1) dict.delete();
        end

        // Small table with a tiny alphabet: heavy collisions and full table.
        write_size(11'd16);
        repeat (RAND_WORDS / 4) begin
            rand_word(w, 3, 4);
            send_word(w, 1'($urandom_range(0, 1)));
        end
        wait_drain();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: filelist.f
sv/whtlp_pkg.sv
sv/whtlp_if.sv
sv/whtlp_ram.sv
sv/whtlp_mod.sv
sv/word_hash_table_linear_probe_top.sv
sim/tb.sv
